/* rtl/rgb_block_average_glyph_macros.svh */
// Assertion macros used by the checker file (rbag_checker).
// No dependencies; include by bare file name.
`ifndef RGB_BLOCK_AVERAGE_GLYPH_MACROS_SVH
`define RGB_BLOCK_AVERAGE_GLYPH_MACROS_SVH

// same-cycle implication
`define RBAG_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rbag check failed");

// next-cycle implication
`define RBAG_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rbag check failed");

`endif

/* rtl/rbag_pkg.sv */
// Shared constants, types and helpers for the block average core.
// No dependencies.
`timescale 1ns / 1ps
package rbag_pkg;

  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_BLOCK_DIM = 256;
  localparam int COL_W    = $clog2(MAX_COLUMNS);
  localparam int SUM_W    = 24;
  localparam int RAM_W    = 3 * SUM_W;
  localparam int CNT_W    = 17;             // bw*bh up to 65536
  localparam int PROD_W   = 16 + SUM_W;
  localparam int DVD_W    = 42;
  localparam int DSR_W    = CNT_W + 16;
  localparam int DIT_W    = $clog2(DVD_W);

  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46872;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BLOCK_WIDTH  = 3'd2,
    REG_BLOCK_HEIGHT = 3'd3,
    REG_COLUMNS      = 3'd4,
    REG_ROWS         = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LUMA  = 2'd0,
    OP_RED   = 2'd1,
    OP_GREEN = 2'd2,
    OP_BLUE  = 2'd3
  } div_op_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ACC    = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DLOAD  = 7'b0001000,
    S_DITER  = 7'b0010000,
    S_DSTORE = 7'b0100000,
    S_PUSH   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    acc;
    logic    mul_en;
    logic    mul_add;
    logic [1:0] mul_sel;
    logic    div_load;
    logic    div_step;
    logic    div_store;
    div_op_t div_sel;
    logic    push;
  } cmd_t;

  typedef struct packed {
    logic block_end;
    logic out_free;
  } status_t;

  function automatic logic [1:0] glyph_of(input logic [7:0] l);
    logic [1:0] g;
    if (l >= 8'd213)      g = 2'd3;
    else if (l >= 8'd128) g = 2'd2;
    else if (l >= 8'd43)  g = 2'd1;
    else                  g = 2'd0;
    return g;
  endfunction

endpackage

/* rtl/rbag_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module rbag_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/rbag_ctrl.sv */
// Sequencer for the block average core.
// Depends on rbag_pkg.
`timescale 1ns / 1ps
module rbag_ctrl import rbag_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);
  state_t           state_r, state_nxt;
  logic [1:0]       mul_cnt_r, mul_cnt_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [DIT_W-1:0] it_r, it_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    mul_cnt_nxt = mul_cnt_r;
    op_nxt      = op_r;
    it_nxt      = it_r;
    cmd         = '0;
    cmd.div_sel = div_op_t'(op_r);
    cmd.mul_sel = mul_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc     = 1'b1;
        mul_cnt_nxt = 2'd0;
        state_nxt   = sts.block_end ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul_en  = (mul_cnt_r != 2'd3);
        cmd.mul_add = (mul_cnt_r != 2'd0);
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        if (mul_cnt_r == 2'd3) begin
          op_nxt    = OP_LUMA;
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        it_nxt       = '0;
        state_nxt    = S_DITER;
      end
      S_DITER: begin
        cmd.div_step = 1'b1;
        it_nxt       = it_r + 1'b1;
        if (it_r == DIT_W'(DVD_W - 1)) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        op_nxt        = op_r + 2'd1;
        state_nxt     = (op_r == OP_BLUE) ? S_PUSH : S_DLOAD;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mul_cnt_r <= '0;
      op_r      <= '0;
      it_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      mul_cnt_r <= mul_cnt_nxt;
      op_r      <= op_nxt;
      it_r      <= it_nxt;
    end
  end
endmodule

/* rtl/rbag_dp.sv */
// Datapath: config registers, position counters, column sums RAM,
// luma multiplier, shared restoring divider and output register.
// Depends on rbag_pkg and rbag_ram.
`timescale 1ns / 1ps
module rbag_dp import rbag_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     sts,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_frame_start,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_block_column,
  output logic [11:0] out_block_row,
  output logic [7:0]  out_avg_red,
  output logic [7:0]  out_avg_green,
  output logic [7:0]  out_avg_blue,
  output logic [7:0]  out_luma,
  output logic [1:0]  out_glyph_index,
  output logic        out_frame_done
);
  // config
  logic [12:0] fw_r, fh_r, rows_r;
  logic [8:0]  bw_r, bh_r, cols_r;
  logic [12:0] fwc, fhc, rowsc;
  logic [8:0]  bwc, bhc, colsc;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 13'd640; fh_r <= 13'd480; bw_r <= 9'd8;
      bh_r <= 9'd16;   cols_r <= 9'd80; rows_r <= 13'd30;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FRAME_WIDTH:  fw_r   <= cfg_data;
        REG_FRAME_HEIGHT: fh_r   <= cfg_data;
        REG_BLOCK_WIDTH:  bw_r   <= cfg_data[8:0];
        REG_BLOCK_HEIGHT: bh_r   <= cfg_data[8:0];
        REG_COLUMNS:      cols_r <= cfg_data[8:0];
        REG_ROWS:         rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fwc   = (fw_r == '0) ? 13'd1 : (fw_r > 13'd4096) ? 13'd4096 : fw_r;
  assign fhc   = (fh_r == '0) ? 13'd1 : (fh_r > 13'd4096) ? 13'd4096 : fh_r;
  assign rowsc = (rows_r == '0) ? 13'd1 : (rows_r > 13'd4096) ? 13'd4096 : rows_r;
  assign bwc   = (bw_r == '0) ? 9'd1 : (bw_r > 9'd256) ? 9'd256 : bw_r;
  assign bhc   = (bh_r == '0) ? 9'd1 : (bh_r > 9'd256) ? 9'd256 : bh_r;
  assign colsc = (cols_r == '0) ? 9'd1 : (cols_r > 9'd256) ? 9'd256 : cols_r;

  always_ff @(posedge clk) begin
    count_r <= CNT_W'(bwc) * CNT_W'(bhc);
  end

  // position counters (frame start clears them before use)
  logic [11:0] px_r, py_r, px, py;
  logic [7:0]  ix_r, iy_r, ix, iy;
  logic [8:0]  cc_r, cc;
  logic [12:0] cr_r, cr;
  logic        x_end, y_end, active;

  assign px = in_frame_start ? '0 : px_r;
  assign py = in_frame_start ? '0 : py_r;
  assign ix = in_frame_start ? '0 : ix_r;
  assign iy = in_frame_start ? '0 : iy_r;
  assign cc = in_frame_start ? '0 : cc_r;
  assign cr = in_frame_start ? '0 : cr_r;

  assign x_end  = ({1'b0, ix} + 9'd1) >= bwc;
  assign y_end  = ({1'b0, iy} + 9'd1) >= bhc;
  assign active = (cc < colsc) && (cr < rowsc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; ix_r <= '0; iy_r <= '0; cc_r <= '0; cr_r <= '0;
    end else if (cmd.capture) begin
      px_r <= px; py_r <= py; ix_r <= ix; iy_r <= iy; cc_r <= cc; cr_r <= cr;
      if (({1'b0, px} + 13'd1) >= fwc) begin
        px_r <= '0; ix_r <= '0; cc_r <= '0;
        if (({1'b0, py} + 13'd1) >= fhc) begin
          py_r <= '0; iy_r <= '0; cr_r <= '0;
        end else begin
          py_r <= py + 12'd1;
          if (y_end) begin
            iy_r <= '0;
            if (cr < rowsc) cr_r <= cr + 13'd1;
          end else begin
            iy_r <= iy + 8'd1;
          end
        end
      end else begin
        px_r <= px + 12'd1;
        if (x_end) begin
          ix_r <= '0;
          if (cc < colsc) cc_r <= cc + 9'd1;
        end else begin
          ix_r <= ix + 8'd1;
        end
      end
    end
  end

  // per-pixel latches
  logic [COL_W-1:0] col_l;
  logic [11:0]      row_l;
  logic             first_l, active_l, end_r, done_l;
  logic [7:0]       r_l, g_l, b_l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r <= 1'b0;
    end else if (cmd.capture) begin
      end_r <= active && x_end && y_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_l    <= cc[COL_W-1:0];
      row_l    <= cr[11:0];
      first_l  <= (ix == '0) && (iy == '0);
      active_l <= active;
      done_l   <= (({1'b0, cc} + 10'd1) == {1'b0, colsc}) &&
                  (({1'b0, cr} + 14'd1) == {1'b0, rowsc});
      r_l <= in_red; g_l <= in_green; b_l <= in_blue;
    end
  end

  assign sts.block_end = end_r;

  // column sums
  logic [RAM_W-1:0]       rd_data, wr_data;
  logic [MAX_COLUMNS-1:0] cvalid_r;
  logic [SUM_W-1:0]       base_r, base_g, base_b;
  logic [SUM_W-1:0]       sum_r, sum_g, sum_b;
  logic                   use_old;

  assign use_old = !first_l && cvalid_r[col_l];
  assign base_r  = use_old ? rd_data[SUM_W-1:0]         : '0;
  assign base_g  = use_old ? rd_data[2*SUM_W-1:SUM_W]   : '0;
  assign base_b  = use_old ? rd_data[3*SUM_W-1:2*SUM_W] : '0;
  assign wr_data = {base_b + SUM_W'(b_l), base_g + SUM_W'(g_l), base_r + SUM_W'(r_l)};

  rbag_ram #(.W(RAM_W), .D(MAX_COLUMNS)) u_sums (
    .clk   (clk),
    .we    (cmd.acc && active_l),
    .waddr (col_l),
    .wdata (wr_data),
    .raddr (cc[COL_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
    end else if (cmd.acc && active_l) begin
      cvalid_r[col_l] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sum_r <= wr_data[SUM_W-1:0];
      sum_g <= wr_data[2*SUM_W-1:SUM_W];
      sum_b <= wr_data[3*SUM_W-1:2*SUM_W];
    end
  end

  // weighted sum, one product per cycle
  logic [PROD_W-1:0] prod_r;
  logic [DVD_W-1:0]  num_r;
  logic [15:0]       wsel;
  logic [SUM_W-1:0]  ssel;

  always_comb begin
    case (cmd.mul_sel)
      2'd0:    begin wsel = W_RED;   ssel = sum_r; end
      2'd1:    begin wsel = W_GREEN; ssel = sum_g; end
      default: begin wsel = W_BLUE;  ssel = sum_b; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= wsel * ssel;
    end
    if (cmd.acc) begin
      num_r <= '0;
    end else if (cmd.mul_add) begin
      num_r <= num_r + DVD_W'(prod_r);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DVD_W-1:0] quo_r;
  logic [DSR_W-1:0] rem_r, dsr_r;
  logic [DSR_W:0]   sh;
  logic             ge;
  logic [7:0]       qsat;

  assign sh   = {rem_r, quo_r[DVD_W-1]};
  assign ge   = sh >= {1'b0, dsr_r};
  assign qsat = (|quo_r[DVD_W-1:8]) ? 8'hFF : quo_r[7:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      case (cmd.div_sel)
        OP_LUMA: begin
          quo_r <= num_r + DVD_W'({count_r, 15'd0});
          dsr_r <= {count_r, 16'd0};
        end
        OP_RED: begin
          quo_r <= DVD_W'(sum_r);
          dsr_r <= DSR_W'(count_r);
        end
        OP_GREEN: begin
          quo_r <= DVD_W'(sum_g);
          dsr_r <= DSR_W'(count_r);
        end
        default: begin
          quo_r <= DVD_W'(sum_b);
          dsr_r <= DSR_W'(count_r);
        end
      endcase
    end else if (cmd.div_step) begin
      rem_r <= ge ? DSR_W'(sh - {1'b0, dsr_r}) : sh[DSR_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  logic [7:0] luma_s, avg_r_s, avg_g_s, avg_b_s;

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        OP_LUMA:  luma_s  <= qsat;
        OP_RED:   avg_r_s <= qsat;
        OP_GREEN: avg_g_s <= qsat;
        default:  avg_b_s <= qsat;
      endcase
    end
  end

  // output register
  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_block_column <= col_l;
      out_block_row    <= row_l;
      out_avg_red      <= avg_r_s;
      out_avg_green    <= avg_g_s;
      out_avg_blue     <= avg_b_s;
      out_luma         <= luma_s;
      out_glyph_index  <= glyph_of(luma_s);
      out_frame_done   <= done_l;
    end
  end
endmodule

/* rtl/rgb_block_average_glyph.sv */
// Top level of the RGB block average / luma / glyph core.
// Depends on rbag_pkg, rbag_ctrl, rbag_dp (and rbag_ram below it).
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | input     | in_valid / in_ready   | frame_start, red, green, blue
//  out_    | output    | out_valid / out_ready | block pos, averages, luma, glyph
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A pixel beat that does not close a block is a capture with sums RAM read,
// then a read-modify-write of the column sums.
// A block-closing beat adds the weighted luma sum and 4 divides (luma, red,
// green, blue) on the one shared restoring divider before the result push.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// position counters and the per-column valid bits; no clearing pass.
// A finished result sits in the output register; the next pixel beat is taken
// while it waits, and only the next result push stalls on out_ready.
`timescale 1ns / 1ps
module rgb_block_average_glyph import rbag_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_frame_start,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_block_column,
  output logic [11:0] out_block_row,
  output logic [7:0]  out_avg_red,
  output logic [7:0]  out_avg_green,
  output logic [7:0]  out_avg_blue,
  output logic [7:0]  out_luma,
  output logic [1:0]  out_glyph_index,
  output logic        out_frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  cmd_t    cmd;
  status_t sts;

  // register writes are taken at any time
  assign cfg_ready = 1'b1;

  rbag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbag_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_frame_start   (in_frame_start),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_block_column (out_block_column),
    .out_block_row    (out_block_row),
    .out_avg_red      (out_avg_red),
    .out_avg_green    (out_avg_green),
    .out_avg_blue     (out_avg_blue),
    .out_luma         (out_luma),
    .out_glyph_index  (out_glyph_index),
    .out_frame_done   (out_frame_done)
  );
endmodule

/* rtl/rbag_checker.sv */
// Port-level checks for the block average core, bound to the top level.
// Depends on rgb_block_average_glyph_macros.svh.
`timescale 1ns / 1ps
`include "rgb_block_average_glyph_macros.svh"
module rbag_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_luma,
  input logic [1:0]  out_glyph_index
);
  // glyph level implied by the luma on the port
  logic [1:0] glyph_exp;
  assign glyph_exp = (out_luma >= 8'd213) ? 2'd3 :
                     (out_luma >= 8'd128) ? 2'd2 :
                     (out_luma >= 8'd43)  ? 2'd1 : 2'd0;

  `RBAG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `RBAG_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_luma))
  `RBAG_ASSERT_NOW(a_glyph, clk, rst_n, out_valid, out_glyph_index == glyph_exp)
  `RBAG_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind rgb_block_average_glyph rbag_checker u_rbag_checker (.*);
